### sv/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, widths and register codes of the ray/triangle intersector.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int CW      = 32;   // coordinate width
	localparam int EW      = 33;   // edge and offset width
	localparam int HW      = 67;   // cross product width
	localparam int PW      = 100;  // product of an edge and a cross product
	localparam int SW      = 102;  // dot product width
	localparam int DW      = 31;   // distance and threshold width
	localparam int AW      = 3;    // register index width
	localparam int LO_BITS = 34;   // low slice of a split multiplication
	localparam int COORD_FRAC_BITS_DEF = 16;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EW-1:0] edge_t;

	typedef enum logic [AW-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_DET_EPS  = 3'd6,
		REG_MIN_DIST = 3'd7
	} reg_idx_t;

	typedef struct packed {
		coord_t vertex0_x;
		coord_t vertex0_y;
		coord_t vertex0_z;
		coord_t vertex1_x;
		coord_t vertex1_y;
		coord_t vertex1_z;
		coord_t vertex2_x;
		coord_t vertex2_y;
		coord_t vertex2_z;
	} tri_in_t;

	typedef struct packed {
		logic          hit;
		logic [DW-1:0] hit_distance;
	} tri_out_t;

	typedef struct packed {
		logic [2:0][CW-1:0] origin;
		logic [2:0][CW-1:0] dir;
		logic [DW-1:0]      det_epsilon;
		logic [DW-1:0]      min_distance;
	} ray_cfg_t;

	// One queue entry: the two triangle edges and the origin offset from vertex 0.
	typedef struct packed {
		logic [2:0][EW-1:0] e1;
		logic [2:0][EW-1:0] e2;
		logic [2:0][EW-1:0] s;
	} edges_t;

	// Status handed from the classification stage to the divider.
	typedef struct packed {
		logic          miss;
		logic [SW-1:0] det;
		logic [SW-1:0] nt;
	} cls_t;

	function automatic edge_t sub_ext(input coord_t a, input coord_t b);
		sub_ext = EW'(a) - EW'(b);
	endfunction

endpackage

### sv/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Accepts triangles and forms the edges e1 and e2 and the origin offset s.
// ----------------------------------------------------------------------------
module rti_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  rti_pkg::tri_in_t  in_item,
	input  rti_pkg::ray_cfg_t cfg,
	output logic              push,
	output rti_pkg::edges_t   push_data
);

	rti_pkg::coord_t v0 [3];
	rti_pkg::coord_t v1 [3];
	rti_pkg::coord_t v2 [3];
	rti_pkg::edges_t edges;
	logic            valid_s1;
	rti_pkg::edges_t edges_s1;

	always_comb begin
		v0[0] = in_item.vertex0_x;
		v0[1] = in_item.vertex0_y;
		v0[2] = in_item.vertex0_z;
		v1[0] = in_item.vertex1_x;
		v1[1] = in_item.vertex1_y;
		v1[2] = in_item.vertex1_z;
		v2[0] = in_item.vertex2_x;
		v2[1] = in_item.vertex2_y;
		v2[2] = in_item.vertex2_z;
		for (int i = 0; i < 3; i++) begin
			edges.e1[i] = rti_pkg::sub_ext(v1[i], v0[i]);
			edges.e2[i] = rti_pkg::sub_ext(v2[i], v0[i]);
			edges.s[i]  = rti_pkg::sub_ext($signed(cfg.origin[i]), v0[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edges_s1 <= edges;
		end
	end

	assign push      = valid_s1;
	assign push_data = edges_s1;

endmodule

### sv/rti_fifo.sv
// ----------------------------------------------------------------------------
// rti_fifo
// Short queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module rti_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rti_pkg::edges_t push_data,
	input  logic            pop,
	output logic            empty,
	output logic            full,
	output rti_pkg::edges_t pop_data
);

	localparam int DEPTH = 4;

	rti_pkg::edges_t       mem [DEPTH];
	logic [1:0]            wr_ptr_q;
	logic [1:0]            rd_ptr_q;
	logic [2:0]            count_q;
	logic                  do_push;
	logic                  do_pop;

	assign empty    = (count_q == 3'd0);
	assign full     = (count_q == 3'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 3'(do_push) - 3'(do_pop);
		end
	end

endmodule

### sv/rti_back.sv
// ----------------------------------------------------------------------------
// rti_back
// Cross and dot products, determinant and the barycentric range checks.
// ----------------------------------------------------------------------------
module rti_back #(
	parameter int COORD_FRAC_BITS = rti_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rti_pkg::edges_t   in_data,
	input  rti_pkg::ray_cfg_t cfg,
	output logic              out_valid,
	output rti_pkg::cls_t     out_cls
);

	localparam int EW = rti_pkg::EW;
	localparam int HW = rti_pkg::HW;
	localparam int PW = rti_pkg::PW;
	localparam int SW = rti_pkg::SW;
	localparam int LB = rti_pkg::LO_BITS;

	logic signed [EW-1:0] dir [3];
	logic signed [EW-1:0] e1 [3];
	logic signed [EW-1:0] e2 [3];
	logic signed [EW-1:0] s [3];

	logic signed [2*EW-1:0] hp_s1 [6];
	logic signed [2*EW-1:0] qp_s1 [6];
	logic signed [EW-1:0]   e1_s1 [3];
	logic signed [EW-1:0]   e2_s1 [3];
	logic signed [EW-1:0]   s_s1 [3];

	logic signed [HW-1:0] h_s2 [3];
	logic signed [HW-1:0] q_s2 [3];
	logic signed [EW-1:0] e1_s2 [3];
	logic signed [EW-1:0] e2_s2 [3];
	logic signed [EW-1:0] s_s2 [3];

	logic signed [EW-1:0]      mb [12];
	logic signed [HW-1:0]      ma [12];
	logic signed [EW+LB:0]     plo_s3 [12];
	logic signed [HW-LB+EW-1:0] phi_s3 [12];

	logic signed [PW-1:0] prod_s4 [12];
	logic signed [SW-1:0] dot_s5 [4];

	logic signed [SW-1:0] det;
	logic signed [SW-1:0] nu;
	logic signed [SW-1:0] nv;
	logic signed [SW-1:0] nt;
	logic signed [SW-1:0] thr;
	logic signed [SW-1:0] uv;
	logic                 miss;

	logic [5:0]           valid_q;
	rti_pkg::cls_t        cls_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir[i] = EW'($signed(cfg.dir[i]));
			e1[i]  = $signed(in_data.e1[i]);
			e2[i]  = $signed(in_data.e2[i]);
			s[i]   = $signed(in_data.s[i]);
		end
	end

	// Stage 1: the products of both cross products, dir x e2 and s x e1.
	always_ff @(posedge clk) begin
		if (in_valid) begin
			hp_s1[0] <= dir[1] * e2[2];
			hp_s1[1] <= dir[2] * e2[1];
			hp_s1[2] <= dir[2] * e2[0];
			hp_s1[3] <= dir[0] * e2[2];
			hp_s1[4] <= dir[0] * e2[1];
			hp_s1[5] <= dir[1] * e2[0];
			qp_s1[0] <= s[1] * e1[2];
			qp_s1[1] <= s[2] * e1[1];
			qp_s1[2] <= s[2] * e1[0];
			qp_s1[3] <= s[0] * e1[2];
			qp_s1[4] <= s[0] * e1[1];
			qp_s1[5] <= s[1] * e1[0];
			e1_s1 <= e1;
			e2_s1 <= e2;
			s_s1  <= s;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			h_s2[i] <= HW'(hp_s1[2*i]) - HW'(hp_s1[2*i+1]);
			q_s2[i] <= HW'(qp_s1[2*i]) - HW'(qp_s1[2*i+1]);
		end
		e1_s2 <= e1_s1;
		e2_s2 <= e2_s1;
		s_s2  <= s_s1;
	end

	// Stage 3: each wide product is split into a low and a high partial product.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mb[i]     = e1_s2[i];
			ma[i]     = h_s2[i];
			mb[3 + i] = s_s2[i];
			ma[3 + i] = h_s2[i];
			mb[6 + i] = dir[i];
			ma[6 + i] = q_s2[i];
			mb[9 + i] = e2_s2[i];
			ma[9 + i] = q_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 12; k++) begin
			plo_s3[k] <= mb[k] * $signed({1'b0, ma[k][LB-1:0]});
			phi_s3[k] <= mb[k] * $signed(ma[k][HW-1:LB]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 12; k++) begin
			prod_s4[k] <= $signed({phi_s3[k], {LB{1'b0}}})
				+ PW'(plo_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < 4; d++) begin
			dot_s5[d] <= SW'(prod_s4[3*d]) + SW'(prod_s4[3*d+1])
				+ SW'(prod_s4[3*d+2]);
		end
	end

	// Stage 6: fold the sign of the determinant into all numerators, then classify.
	always_comb begin
		if (dot_s5[0] < 0) begin
			det = -dot_s5[0];
			nu  = -dot_s5[1];
			nv  = -dot_s5[2];
			nt  = -dot_s5[3];
		end else begin
			det = dot_s5[0];
			nu  = dot_s5[1];
			nv  = dot_s5[2];
			nt  = dot_s5[3];
		end
		thr  = $signed(SW'(cfg.det_epsilon) << (2 * COORD_FRAC_BITS));
		uv   = nu + nv;
		miss = (det == '0) || (det < thr) || (nu < 0) || (nu > det)
			|| (nv < 0) || (uv > det) || (nt < 0);
	end

	always_ff @(posedge clk) begin
		cls_s6.miss <= miss;
		cls_s6.det  <= det;
		cls_s6.nt   <= nt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[4:0], in_valid};
		end
	end

	assign out_valid = valid_q[5];
	assign out_cls   = cls_s6;

endmodule

### sv/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider for the hit distance, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rti_div #(
	parameter int COORD_FRAC_BITS = rti_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rti_pkg::cls_t      in_cls,
	input  logic [rti_pkg::DW-1:0] min_distance,
	output logic               done,
	output rti_pkg::tri_out_t  result
);

	localparam int SW = rti_pkg::SW;
	localparam int DW = rti_pkg::DW;
	localparam int RW = SW + COORD_FRAC_BITS + DW + 1;
	localparam int NS = DW + 1;

	logic [RW-1:0] rem_q  [NS];
	logic [RW-1:0] den_q  [NS];
	logic [DW-1:0] quo_q  [NS];
	logic          miss_q [NS];
	logic          sat_q  [NS];
	logic [NS-1:0] vld_q;

	logic [RW-1:0] num;
	logic [RW-1:0] den;
	logic [DW-1:0] dist_sat;
	logic          hit;
	rti_pkg::tri_out_t res_q;
	logic          done_q;

	assign num = RW'(in_cls.nt) << COORD_FRAC_BITS;
	assign den = RW'(in_cls.det);

	// A quotient of 2^31 or more saturates.
	always_ff @(posedge clk) begin
		rem_q[0]  <= num;
		den_q[0]  <= den;
		quo_q[0]  <= '0;
		miss_q[0] <= in_cls.miss;
		sat_q[0]  <= num >= (den << DW);
	end

	for (genvar j = 1; j < NS; j++) begin : g_step
		localparam int B = DW - j;
		logic [RW-1:0] trial;
		assign trial = den_q[j-1] << B;
		always_ff @(posedge clk) begin
			den_q[j]  <= den_q[j-1];
			miss_q[j] <= miss_q[j-1];
			sat_q[j]  <= sat_q[j-1];
			if (rem_q[j-1] >= trial) begin
				rem_q[j]    <= rem_q[j-1] - trial;
				quo_q[j]    <= quo_q[j-1] | (DW'(1) << B);
			end else begin
				rem_q[j]    <= rem_q[j-1];
				quo_q[j]    <= quo_q[j-1];
			end
		end
	end

	assign dist_sat = sat_q[NS-1] ? '1 : quo_q[NS-1];
	assign hit      = !miss_q[NS-1] && (dist_sat > min_distance);

	always_ff @(posedge clk) begin
		res_q.hit          <= hit;
		res_q.hit_distance <= hit ? dist_sat : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[NS-2:0], in_valid};
			done_q <= vld_q[NS-1];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### sv/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test against a ray held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   The ray (origin, direction), the determinant threshold and the minimum
//   distance are written through cfg_we/cfg_addr/cfg_wdata while no item is
//   in flight. Each triangle is an item on in_item, taken at a clock edge
//   where start is high and busy is low. Exactly one result per item comes
//   out on result, marked by done for one cycle, in order.
//   The path runs through one front register, the queue, six arithmetic
//   stages and a 32-stage divider with an output register. Throughput is
//   one item per cycle while busy is low; every multiplier and divider
//   step is its own pipeline stage. Busy rises only if the queue between
//   front and back were full, which cannot happen as the back end drains
//   it every cycle. Reset clears the registers to a ray along +x from the
//   origin, a threshold of one and a minimum distance of zero, and empties
//   the pipeline. The receiver cannot stall; results must be taken as shown.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
	parameter int COORD_FRAC_BITS = rti_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  rti_pkg::tri_in_t        in_item,
	output logic                    done,
	output rti_pkg::tri_out_t       result,
	input  logic                    cfg_we,
	input  logic [rti_pkg::AW-1:0]  cfg_addr,
	input  logic [rti_pkg::CW-1:0]  cfg_wdata
);

	rti_pkg::ray_cfg_t cfg_q;
	logic              accept;
	logic              push;
	rti_pkg::edges_t   push_data;
	logic              empty;
	logic              full;
	rti_pkg::edges_t   pop_data;
	logic              cls_valid;
	rti_pkg::cls_t     cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{origin: '0,
				dir: {rti_pkg::CW'(0), rti_pkg::CW'(0),
					rti_pkg::CW'(1) << COORD_FRAC_BITS},
				det_epsilon: rti_pkg::DW'(1),
				min_distance: '0};
		end else if (cfg_we) begin
			case (rti_pkg::reg_idx_t'(cfg_addr))
				rti_pkg::REG_ORIGIN_X: cfg_q.origin[0]    <= cfg_wdata;
				rti_pkg::REG_ORIGIN_Y: cfg_q.origin[1]    <= cfg_wdata;
				rti_pkg::REG_ORIGIN_Z: cfg_q.origin[2]    <= cfg_wdata;
				rti_pkg::REG_DIR_X:    cfg_q.dir[0]       <= cfg_wdata;
				rti_pkg::REG_DIR_Y:    cfg_q.dir[1]       <= cfg_wdata;
				rti_pkg::REG_DIR_Z:    cfg_q.dir[2]       <= cfg_wdata;
				rti_pkg::REG_DET_EPS:  cfg_q.det_epsilon  <= cfg_wdata[rti_pkg::DW-1:0];
				rti_pkg::REG_MIN_DIST: cfg_q.min_distance <= cfg_wdata[rti_pkg::DW-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = full;
	assign accept = start && !busy;

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_item),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data)
	);

	rti_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (!empty),
		.empty     (empty),
		.full      (full),
		.pop_data  (pop_data)
	);

	rti_back #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!empty),
		.in_data   (pop_data),
		.cfg       (cfg_q),
		.out_valid (cls_valid),
		.out_cls   (cls)
	);

	rti_div #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cls_valid),
		.in_cls       (cls),
		.min_distance (cfg_q.min_distance),
		.done         (done),
		.result       (result)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.hit_distance == '0)
		else $error("miss reported with a nonzero distance");

	a_hit_above_min: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> result.hit_distance > cfg_q.min_distance)
		else $error("hit reported at or below the minimum distance");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("queue between front and back filled up");

endmodule
